@@ sv/random_walk_grid_carver_top_assert.svh @@
// Assertion macros shared by the random-walk grid carver modules.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef RANDOM_WALK_GRID_CARVER_TOP_ASSERT_SVH
`define RANDOM_WALK_GRID_CARVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RWGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rwgc_pkg.sv @@
// Types and constants of the random-walk grid carver.
// No dependencies; used by rwgc_ctrl, rwgc_datapath and the top level.
package rwgc_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	localparam logic [1:0] DIR_POS_X = 2'd0;
	localparam logic [1:0] DIR_NEG_X = 2'd1;
	localparam logic [1:0] DIR_POS_Y = 2'd2;
	localparam logic [1:0] DIR_NEG_Y = 2'd3;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WIGGLE_PCT  = 2'd2;

	localparam logic [6:0] GRID_SIZE_RESET = 7'd64;
	localparam logic [6:0] WIGGLE_RESET    = 7'd0;

	localparam int FLOOR_PCT     = 33;
	localparam int PCT_DIVISOR   = 100;
	localparam int MIN_FLOOR     = 16;
	localparam int STEPS_PER_CELL = 24;

	// floor(cells * 33 / 100) == (cells * FLOOR_RECIP) >> FLOOR_RECIP_SHIFT
	// for every cell count below 233016
	localparam int FLOOR_RECIP       = 5536482;
	localparam int FLOOR_RECIP_SHIFT = 24;

	typedef enum logic [3:0] {
		ST_INIT_CLEAR,
		ST_IDLE,
		ST_START_CLEAR,
		ST_START_MUL,
		ST_START_PROD,
		ST_START_FIN,
		ST_STEP_MOVE,
		ST_STEP_CARVE,
		ST_READ_ADDR,
		ST_READ_TILE,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic latch;       // take the input payload
		logic clear;       // write one map row in the clearing sweep
		logic clear_mark;  // set the start cell while sweeping
		logic mul;         // cells = width * height
		logic prod;        // cells times the reciprocal of 100/33
		logic fin;         // set floor target and step limit
		logic step_move;   // move or bounce, read the entered row
		logic step_carve;  // carve the entered cell if wall
		logic read_addr;   // address the requested tile row
		logic read_tile;   // pick the tile bit
		logic load_out;    // load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic row_last;
		logic walk_done;
		logic in_grid;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/rwgc_in_if.sv @@
// Input channel of the random-walk grid carver: valid/ready plus one item.
// No dependencies.
interface rwgc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [5:0] coord_x;
	logic [5:0] coord_y;
	logic [6:0] wiggle_roll;
	logic [1:0] turn_dir;
	logic [1:0] bounce_dir;

	modport source (output valid, command, coord_x, coord_y, wiggle_roll, turn_dir,
		bounce_dir, input ready);
	modport sink (input valid, command, coord_x, coord_y, wiggle_roll, turn_dir,
		bounce_dir, output ready);
endinterface

@@ sv/rwgc_out_if.sv @@
// Result channel of the random-walk grid carver: valid/ready plus one result.
// No dependencies.
interface rwgc_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  walker_x;
	logic [5:0]  walker_y;
	logic        carved_now;
	logic        tile_is_floor;
	logic [12:0] floor_count;
	logic        finished;

	modport source (output valid, walker_x, walker_y, carved_now, tile_is_floor,
		floor_count, finished, input ready);
	modport sink (input valid, walker_x, walker_y, carved_now, tile_is_floor,
		floor_count, finished, output ready);
endinterface

@@ sv/rwgc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rwgc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/rwgc_ctrl.sv @@
// Controller of the random-walk grid carver: sequences start, step and read.
// Depends on rwgc_pkg and random_walk_grid_carver_top_assert.svh.
`include "random_walk_grid_carver_top_assert.svh"

module rwgc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_command,
	output logic               in_ready,
	input  rwgc_pkg::dp_stat_t stat,
	output rwgc_pkg::dp_cmd_t  cmd
);
	import rwgc_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.row_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (command_t'(in_command))
						CMD_START: state_d = ST_START_CLEAR;
						CMD_STEP:  state_d = stat.walk_done ? ST_RESULT : ST_STEP_MOVE;
						CMD_READ:  state_d = ST_READ_ADDR;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_START_CLEAR: begin
				cmd.clear      = 1'b1;
				cmd.clear_mark = 1'b1;
				if (stat.row_last) begin
					state_d = ST_START_MUL;
				end
			end
			ST_START_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_START_PROD;
			end
			ST_START_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_START_FIN;
			end
			ST_START_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_RESULT;
			end
			ST_STEP_MOVE: begin
				cmd.step_move = 1'b1;
				state_d = stat.in_grid ? ST_STEP_CARVE : ST_RESULT;
			end
			ST_STEP_CARVE: begin
				cmd.step_carve = 1'b1;
				state_d = ST_RESULT;
			end
			ST_READ_ADDR: begin
				cmd.read_addr = 1'b1;
				state_d = ST_READ_TILE;
			end
			ST_READ_TILE: begin
				cmd.read_tile = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`RWGC_ASSERT_NEXT(a_accept_leaves_idle, state_q == ST_IDLE && in_valid, state_q != ST_IDLE, "accepted item did not start work")
	`RWGC_ASSERT_NEXT(a_result_waits, state_q == ST_RESULT && !stat.out_free, state_q == ST_RESULT, "result dropped while output busy")
	`RWGC_ASSERT_NEXT(a_init_sweep_once, state_q != ST_INIT_CLEAR, state_q != ST_INIT_CLEAR, "reset sweep reentered")
endmodule

@@ sv/rwgc_datapath.sv @@
// Datapath of the random-walk grid carver: registers, walker, targets, map RAM.
// Depends on rwgc_pkg, rwgc_ram and random_walk_grid_carver_top_assert.svh.
`include "random_walk_grid_carver_top_assert.svh"

module rwgc_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_wdata,
	input  logic [1:0]         in_command,
	input  logic [5:0]         in_coord_x,
	input  logic [5:0]         in_coord_y,
	input  logic [6:0]         in_wiggle_roll,
	input  logic [1:0]         in_turn_dir,
	input  logic [1:0]         in_bounce_dir,
	input  rwgc_pkg::dp_cmd_t  cmd,
	output rwgc_pkg::dp_stat_t stat,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [5:0]         out_walker_x,
	output logic [5:0]         out_walker_y,
	output logic               out_carved_now,
	output logic               out_tile_is_floor,
	output logic [12:0]        out_floor_count,
	output logic               out_finished
);
	import rwgc_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PXW   = $clog2(MAX_WIDTH);
	localparam int PYW   = $clog2(MAX_HEIGHT);
	localparam int CELLW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int PRODW = CELLW + FLOOR_RECIP_SHIFT;
	localparam int STEPW = CELLW + 5;

	typedef logic [MAX_WIDTH-1:0] row_t;

	// configuration
	logic [6:0] grid_width_q, grid_height_q, wiggle_q;
	// latched item
	command_t   cmd_q;
	logic [5:0] cx_q, cy_q;
	logic [6:0] roll_q;
	logic [1:0] turn_q, bounce_q;
	// walk state
	logic [PXW-1:0]   pos_x_q;
	logic [PYW-1:0]   pos_y_q;
	logic [1:0]       heading_q;
	logic [CELLW-1:0] carved_total_q, target_q;
	logic [STEPW-1:0] step_total_q, limit_q;
	logic             carved_q, tile_q;
	// sweep and target arithmetic
	logic [PYW-1:0]   row_q;
	logic [CELLW-1:0] cells_q;
	logic [PRODW-1:0] div_n_q;

	logic [WW-1:0]    w_c;
	logic [HW-1:0]    h_c;
	logic [PXW-1:0]   start_x, nx;
	logic [PYW-1:0]   start_y, ny;
	logic [1:0]       head_n;
	logic             in_grid, in_bounds, walk_done;
	logic [CELLW-1:0] quot, tgt;
	logic [STEPW-1:0] lim_raw, lim;
	row_t             pos_bit, rd_row, ram_wdata;
	logic             ram_we;
	logic [PYW-1:0]   ram_waddr, ram_raddr;

	always_comb begin
		if (grid_width_q == '0) begin
			w_c = WW'(1);
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h_c = HW'(1);
		end else if (32'(grid_height_q) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(grid_height_q);
		end
	end

	// start position saturates to the last column and row in use
	assign start_x = (32'(in_coord_x) < 32'(w_c)) ? PXW'(in_coord_x) : PXW'(w_c - WW'(1));
	assign start_y = (32'(in_coord_y) < 32'(h_c)) ? PYW'(in_coord_y) : PYW'(h_c - HW'(1));

	assign head_n = (roll_q < wiggle_q) ? turn_q : heading_q;

	always_comb begin
		nx = pos_x_q;
		ny = pos_y_q;
		case (head_n)
			DIR_POS_X: begin
				in_grid = (32'(pos_x_q) + 32'd1) < 32'(w_c);
				nx      = pos_x_q + PXW'(1);
			end
			DIR_NEG_X: begin
				in_grid = pos_x_q != '0;
				nx      = pos_x_q - PXW'(1);
			end
			DIR_POS_Y: begin
				in_grid = (32'(pos_y_q) + 32'd1) < 32'(h_c);
				ny      = pos_y_q + PYW'(1);
			end
			default: begin
				in_grid = pos_y_q != '0;
				ny      = pos_y_q - PYW'(1);
			end
		endcase
	end

	assign walk_done = (carved_total_q >= target_q) || (step_total_q >= limit_q);
	assign in_bounds = (32'(cx_q) < 32'(w_c)) && (32'(cy_q) < 32'(h_c));

	// divide by 100 through the registered reciprocal product
	assign quot    = div_n_q[PRODW-1 -: CELLW];
	assign tgt     = (quot < CELLW'(MIN_FLOOR)) ? CELLW'(MIN_FLOOR) : quot;
	assign lim_raw = STEPW'(cells_q) * STEPW'(STEPS_PER_CELL);
	assign lim     = (lim_raw < STEPW'(tgt)) ? STEPW'(tgt) : lim_raw;

	assign pos_bit = row_t'(1) << pos_x_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = '0;
		if (cmd.clear) begin
			ram_we = 1'b1;
			if (cmd.clear_mark && row_q == pos_y_q) begin
				ram_wdata = pos_bit;
			end
		end else if (cmd.step_carve) begin
			ram_we    = !rd_row[pos_x_q];
			ram_waddr = pos_y_q;
			ram_wdata = rd_row | pos_bit;
		end
		ram_raddr = cmd.read_addr ? PYW'(cy_q) : ny;
	end

	rwgc_ram #(
		.WIDTH(MAX_WIDTH),
		.DEPTH(MAX_HEIGHT)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_SIZE_RESET;
			grid_height_q <= GRID_SIZE_RESET;
			wiggle_q      <= WIGGLE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				REG_WIGGLE_PCT:  wiggle_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			heading_q      <= '0;
			carved_total_q <= '0;
			step_total_q   <= '0;
			target_q       <= '0;
			limit_q        <= '0;
			row_q          <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (cmd.latch && command_t'(in_command) == CMD_START) begin
				pos_x_q        <= start_x;
				pos_y_q        <= start_y;
				heading_q      <= in_turn_dir;
				carved_total_q <= CELLW'(1);
				step_total_q   <= '0;
			end
			if (cmd.clear) begin
				row_q <= (row_q == PYW'(MAX_HEIGHT - 1)) ? '0 : row_q + PYW'(1);
			end
			if (cmd.fin) begin
				target_q <= tgt;
				limit_q  <= lim;
			end
			if (cmd.step_move) begin
				step_total_q <= step_total_q + STEPW'(1);
				if (in_grid) begin
					pos_x_q   <= nx;
					pos_y_q   <= ny;
					heading_q <= head_n;
				end else begin
					heading_q <= bounce_q;
				end
			end
			if (cmd.step_carve && !rd_row[pos_x_q]) begin
				carved_total_q <= carved_total_q + CELLW'(1);
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q    <= command_t'(in_command);
			cx_q     <= in_coord_x;
			cy_q     <= in_coord_y;
			roll_q   <= in_wiggle_roll;
			turn_q   <= in_turn_dir;
			bounce_q <= in_bounce_dir;
			carved_q <= command_t'(in_command) == CMD_START;
			tile_q   <= 1'b0;
		end
		if (cmd.mul) begin
			cells_q <= CELLW'(w_c * h_c);
		end
		if (cmd.prod) begin
			div_n_q <= PRODW'(cells_q) * PRODW'(FLOOR_RECIP);
		end
		if (cmd.step_carve && !rd_row[pos_x_q]) begin
			carved_q <= 1'b1;
		end
		if (cmd.read_tile) begin
			tile_q <= (cmd_q == CMD_READ) && in_bounds && rd_row[PXW'(cx_q)];
		end
		if (cmd.load_out) begin
			out_walker_x      <= 6'(pos_x_q);
			out_walker_y      <= 6'(pos_y_q);
			out_carved_now    <= carved_q;
			out_tile_is_floor <= tile_q;
			out_floor_count   <= 13'(carved_total_q);
			out_finished      <= walk_done;
		end
	end

	assign stat.row_last  = row_q == PYW'(MAX_HEIGHT - 1);
	assign stat.walk_done = walk_done;
	assign stat.in_grid   = in_grid;
	assign stat.out_free  = !out_valid || out_ready;

	`RWGC_ASSERT_NEXT(a_step_counts_one, cmd.step_move, step_total_q == STEPW'($past(step_total_q) + 1'b1), "step count did not advance by one")
	`RWGC_ASSERT_NEXT(a_start_count_one, cmd.latch && in_command == CMD_START, carved_total_q == CELLW'(1), "start did not count its cell")
	`RWGC_ASSERT_NOW(a_carve_in_map, cmd.step_carve, 32'(pos_x_q) < MAX_WIDTH && 32'(pos_y_q) < MAX_HEIGHT, "carve outside the map")
endmodule

@@ sv/random_walk_grid_carver_top.sv @@
// Top level of the random-walk grid carver: controller, datapath, channels.
// Depends on rwgc_pkg, rwgc_in_if, rwgc_out_if, rwgc_ctrl, rwgc_datapath.

// Random-walk grid carver. A bit map of up to MAX_WIDTH x MAX_HEIGHT cells,
// held in a RAM with one row of MAX_WIDTH bits per word, starts as wall.
// Every transfer on in_ch gives exactly one transfer on out_ch. A start item
// clears the map, places the walker (coordinates saturate to the grid in use),
// takes turn_dir as heading, carves the start cell and sets the floor target
// max(cells*33/100, 16) and the step limit max(cells*24, target). A step item
// rolls against the turn-chance register for a new heading, bounces to
// bounce_dir at the edge, otherwise moves and carves a wall cell it enters;
// once the target or the step limit is reached, steps change nothing and
// report finished. A read item reports one tile (wall outside the grid);
// command 3 only reports.
// Sequence, from the accepting edge to the next accept with out_ch free: a step
// that moves passes move, carve, result, idle; a step that bounces move,
// result, idle; a step after the walk is finished and command 3 result, idle;
// a read tile address, tile pick, result, idle; and a start a row-per-cycle
// clear of the map RAM, then cell count, a reciprocal multiply for the divide
// by 100 and the target select, then result and idle. After reset the block
// clears the map row by row before in_ch.ready first rises; configuration
// writes are taken at any time through cfg_wr_en / cfg_index / cfg_wdata
// (0 grid_width, 1 grid_height, 2 turn chance) and must come while idle.
// A finished result waits in the output register while the next item is
// accepted and worked on.
module random_walk_grid_carver_top #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_wdata,
	rwgc_in_if.sink     in_ch,
	rwgc_out_if.source  out_ch
);
	import rwgc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequence each item: clear sweep, target math, move/carve, tile read
	rwgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_command(in_ch.command),
		.in_ready  (in_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold configuration, walk state and the map; drive the result register
	rwgc_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_command       (in_ch.command),
		.in_coord_x       (in_ch.coord_x),
		.in_coord_y       (in_ch.coord_y),
		.in_wiggle_roll   (in_ch.wiggle_roll),
		.in_turn_dir      (in_ch.turn_dir),
		.in_bounce_dir    (in_ch.bounce_dir),
		.cmd              (cmd),
		.stat             (stat),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_walker_x     (out_ch.walker_x),
		.out_walker_y     (out_ch.walker_y),
		.out_carved_now   (out_ch.carved_now),
		.out_tile_is_floor(out_ch.tile_is_floor),
		.out_floor_count  (out_ch.floor_count),
		.out_finished     (out_ch.finished)
	);
endmodule
